### hdl/bfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KIND_W = 3;
  localparam int ITEM_W = 32;
  localparam int STAT_W = 2;
  localparam int SIZE_W = 5;
  localparam int CMP_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RSV_POP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPLACE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_HELD = 2'd3
  } status_t;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ITEM_W-1:0] item;
  } op_t;

  typedef struct packed {
    status_t           status;
    logic [ITEM_W-1:0] item_out;
    logic              item_valid;
    logic              wake_producers;
    logic              wake_consumers;
    logic [SIZE_W-1:0] slots_used;
    logic [SIZE_W-1:0] entries_stored;
  } res_t;

  // storage access from the control logic
  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [PTR_W-1:0]      raddr;
  } store_req_t;

endpackage

`default_nettype wire

### hdl/bfr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfr_op_if;
  import bfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ITEM_W-1:0] item;

  modport source (output valid, output kind, output item, input ready);
  modport sink   (input valid, input kind, input item, output ready);
endinterface

interface bfr_res_if;
  import bfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ITEM_W-1:0] item_out;
  logic              item_valid;
  logic              wake_producers;
  logic              wake_consumers;
  logic [SIZE_W-1:0] slots_used;
  logic [SIZE_W-1:0] entries_stored;

  modport source (output valid, output status, output item_out, output item_valid,
                  output wake_producers, output wake_consumers, output slots_used,
                  output entries_stored, input ready);
  modport sink   (input valid, input status, input item_out, input item_valid,
                  input wake_producers, input wake_consumers, input slots_used,
                  input entries_stored, output ready);
endinterface

`default_nettype wire

### hdl/bfr_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bfr_store (
  input  wire logic                           clk,
  input  wire bfr_pkg::store_req_t            req,
  output logic [bfr_pkg::DATA_WIDTH-1:0]      rdata
);
  import bfr_pkg::*;

  // ring buffer words; registered read, write-first when both hit one word
  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.we && (req.waddr == req.raddr)) begin
      rdata <= req.wdata;
    end else begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/bfr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfr_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bfr_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                          fire,
  input  wire bfr_pkg::op_t                  op,
  input  wire logic [bfr_pkg::DATA_WIDTH-1:0] rdata,
  output bfr_pkg::store_req_t                req,
  output bfr_pkg::res_t                      res
);
  import bfr_pkg::*;

  logic [PTR_W-1:0]  head_ptr, head_ptr_next;
  logic [PTR_W-1:0]  tail_ptr, tail_ptr_next;
  logic [CNT_W-1:0]  slot_count, slot_count_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [SIZE_W-1:0] max_size;

  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] slots_old_x, slots_new_x;
  logic             held;
  logic             wr;

  function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
    next_index = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    lim = (CMP_W'(max_size) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(max_size);
  end

  assign held        = entry_count < slot_count;
  assign slots_old_x = CMP_W'(slot_count);
  assign slots_new_x = CMP_W'(slot_count_next);

  always_comb begin
    res              = '0;
    res.status       = ST_DONE;
    head_ptr_next    = head_ptr;
    tail_ptr_next    = tail_ptr;
    slot_count_next  = slot_count;
    entry_count_next = entry_count;
    wr               = 1'b0;

    case (op.kind)
      KIND_PUSH, KIND_REPLACE: begin
        if (op.kind == KIND_PUSH && slots_old_x >= lim) begin
          res.status = ST_FULL;
        end else if (op.kind == KIND_REPLACE && !held) begin
          res.status = ST_NO_HELD;
        end else begin
          wr            = 1'b1;
          tail_ptr_next = next_index(tail_ptr);
          if (op.kind == KIND_PUSH) begin
            slot_count_next = slot_count + 1'b1;
          end
          res.wake_consumers = (entry_count == '0);
          entry_count_next   = entry_count + 1'b1;
        end
      end
      KIND_POP, KIND_RSV_POP: begin
        if (entry_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_out     = ITEM_W'(rdata);
          res.item_valid   = 1'b1;
          head_ptr_next    = next_index(head_ptr);
          entry_count_next = entry_count - 1'b1;
          if (op.kind == KIND_POP) begin
            slot_count_next = slot_count - 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        if (!held) begin
          res.status = ST_NO_HELD;
        end else begin
          slot_count_next = slot_count - 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.wake_producers = (slots_old_x >= lim) && (slots_new_x < lim);
    res.slots_used     = SIZE_W'(slot_count_next);
    res.entries_stored = SIZE_W'(entry_count_next);
  end

  assign req.we    = wr && fire;
  assign req.waddr = tail_ptr;
  assign req.wdata = DATA_WIDTH'(op.item);
  // read the head that will be current after this edge
  assign req.raddr = fire ? head_ptr_next : head_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr    <= '0;
      tail_ptr    <= '0;
      slot_count  <= '0;
      entry_count <= '0;
      max_size    <= MAX_SIZE_RST;
    end else begin
      if (cfg_we) begin
        max_size <= cfg_data;
      end
      if (fire) begin
        head_ptr    <= head_ptr_next;
        tail_ptr    <= tail_ptr_next;
        slot_count  <= slot_count_next;
        entry_count <= entry_count_next;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/bounded_fifo_with_slot_reservation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake           Payload
// op       in   op.valid/op.ready   kind, item
// res      out  res.valid/res.ready status, item_out, item_valid, wake_producers,
//                                   wake_consumers, slots_used, entries_stored
// cfg      in   cfg_we              cfg_data (max_size)
//
// One transaction per clock while res is not stalled: an op is held in the input
// register, then its update of pointers, counts and the ring is applied as it moves
// into the result register, which drives res.
// Reset (rst, synchronous) empties the queue and sets max_size to 16.
// A stalled res holds the result register, which in turn holds the input
// register; op.ready drops only when both are full and res is stalled.

module bounded_fifo_with_slot_reservation_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [bfr_pkg::SIZE_W-1:0] cfg_data,
  bfr_op_if.sink                          op,
  bfr_res_if.source                       res
);
  import bfr_pkg::*;

  // input register
  logic in_valid;
  op_t  in_op;

  // result register
  logic out_valid;
  res_t out_res;

  logic                  out_free;
  logic                  fire;
  res_t                  res_comb;
  store_req_t            req;
  logic [DATA_WIDTH-1:0] rdata;

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_valid || res.ready;
  // input op is executed as it moves into the result register
  assign fire     = in_valid && out_free;
  assign op.ready = !in_valid || fire;

  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (fire),
    .op       (in_op),
    .rdata    (rdata),
    .req      (req),
    .res      (res_comb)
  );

  bfr_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (op.ready) begin
        in_valid <= op.valid;
      end
      if (out_free) begin
        out_valid <= fire;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (op.valid && op.ready) begin
      in_op.kind <= op.kind;
      in_op.item <= op.item;
    end
    if (fire) begin
      out_res <= res_comb;
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = out_res.status;
  assign res.item_out       = out_res.item_out;
  assign res.item_valid     = out_res.item_valid;
  assign res.wake_producers = out_res.wake_producers;
  assign res.wake_consumers = out_res.wake_consumers;
  assign res.slots_used     = out_res.slots_used;
  assign res.entries_stored = out_res.entries_stored;

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

// Bench for the bounded FIFO with slot reservation.
// A driver feeds op transactions from a backlog queue.
// A predictor tracks ring, pointers and both counts at each accepted op.
// A monitor checks every res transaction against the oldest prediction.
module tb_top;
  import bfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;  // long res stall used to back up the op side
  localparam int DRAIN_PAD   = 4;    // pipe is two deep; a little margin on top

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;

  bfr_op_if  op_ch ();
  bfr_res_if res_ch ();

  bounded_fifo_with_slot_reservation_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .op       (op_ch),
    .res      (res_ch)
  );

  // ---------------------------------------------------------------
  // Predictor state: a private copy of the queue and its limit.
  // ---------------------------------------------------------------
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  logic [PTR_W-1:0]      q_head = '0;
  logic [PTR_W-1:0]      q_tail = '0;
  logic [SIZE_W-1:0]     q_slots = '0;
  logic [SIZE_W-1:0]     q_entries = '0;
  logic [SIZE_W-1:0]     cfg_max_size = MAX_SIZE_RST;

  res_t want_results [$];  // predicted res transactions, oldest first
  op_t  op_backlog [$];    // ops waiting for the driver

  int ops_queued   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  // knobs set by the sequencer, sampled by driver and monitor
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int hold_req    = 0;

  int   src_gap = 0;
  int   snk_gap = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  op_t  nxt_op;
  res_t got_res;

  // Apply one accepted op to the private queue and record what res must say.
  task automatic predict_op(input logic [KIND_W-1:0] kind, input logic [ITEM_W-1:0] word);
    res_t r;
    logic [SIZE_W-1:0] lim;
    logic [SIZE_W-1:0] old_slots;
    logic held;
    r = '0;
    r.status = ST_DONE;
    // max_size above DEPTH saturates; zero refuses every push
    lim = (cfg_max_size > DEPTH) ? SIZE_W'(DEPTH) : cfg_max_size;
    old_slots = q_slots;
    held = (q_entries < q_slots);  // a slot is held when counts differ
    case (kind)
      KIND_PUSH, KIND_REPLACE: begin
        if (kind == KIND_PUSH && q_slots >= lim) begin
          r.status = ST_FULL;
        end else if (kind == KIND_REPLACE && !held) begin
          r.status = ST_NO_HELD;
        end else begin
          ring[q_tail] = word;
          q_tail = q_tail + 1'b1;
          if (kind == KIND_PUSH) q_slots = q_slots + 1'b1;
          if (q_entries == 0) r.wake_consumers = 1'b1;
          q_entries = q_entries + 1'b1;
        end
      end
      KIND_POP, KIND_RSV_POP: begin
        if (q_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.item_out = ring[q_head];
          r.item_valid = 1'b1;
          q_head = q_head + 1'b1;
          q_entries = q_entries - 1'b1;
          // reserved pop keeps the slot held
          if (kind == KIND_POP) q_slots = q_slots - 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (!held) r.status = ST_NO_HELD;
        else q_slots = q_slots - 1'b1;
      end
      default: ;  // unused kinds: no-op, counts reported as they are
    endcase
    // producers wake when the slot count drops under the limit, including
    // the case where the limit was lowered below the count
    if (old_slots >= lim && q_slots < lim) r.wake_producers = 1'b1;
    r.slots_used = q_slots;
    r.entries_stored = q_entries;
    want_results.push_back(r);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (want_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected res transaction: st=%0d out=%h v=%b slots=%0d ent=%0d",
                 got.status, got.item_out, got.item_valid, got.slots_used, got.entries_stored);
    end else begin
      want = want_results.pop_front();
      results_seen++;
      if (got.status !== want.status || got.item_out !== want.item_out ||
          got.item_valid !== want.item_valid || got.wake_producers !== want.wake_producers ||
          got.wake_consumers !== want.wake_consumers || got.slots_used !== want.slots_used ||
          got.entries_stored !== want.entries_stored) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("res #%0d exp: st=%0d out=%h v=%b wp=%b wc=%b slots=%0d ent=%0d",
                   results_seen, want.status, want.item_out, want.item_valid,
                   want.wake_producers, want.wake_consumers, want.slots_used,
                   want.entries_stored);
          $display("res #%0d got: st=%0d out=%h v=%b wp=%b wc=%b slots=%0d ent=%0d",
                   results_seen, got.status, got.item_out, got.item_valid,
                   got.wake_producers, got.wake_consumers, got.slots_used,
                   got.entries_stored);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------
  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [ITEM_W-1:0] word);
    op_t o;
    o.kind = kind;
    o.item = word;
    op_backlog.push_back(o);
    ops_queued++;
  endtask

  // Sequencer waits until a result has come back for every queued op.
  task automatic wait_drained();
    while (results_seen != ops_queued) @(posedge clk);
  endtask

  // Register write only with the block idle.
  task automatic set_max_size(input logic [SIZE_W-1:0] v);
    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_max_size = v;  // no op can be accepted before the write lands
  endtask

  // Random ops; push_pct steers how hard the queue is filled.
  task automatic queue_random(input int count, input int push_pct);
    int r;
    int s;
    logic [KIND_W-1:0] k;
    logic [ITEM_W-1:0] w;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < push_pct) k = KIND_PUSH;
      else if (s < 40) k = KIND_POP;
      else if (s < 60) k = KIND_RSV_POP;
      else if (s < 80) k = KIND_REPLACE;
      else if (s < 92) k = KIND_RELEASE;
      else k = KIND_W'($urandom_range(5, 7));  // unused kinds
      case ($urandom_range(0, 15))
        0: w = '0;
        1: w = '1;
        default: w = $urandom;
      endcase
      queue_op(k, w);
    end
  endtask

  // ---------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    op_ch.valid = 1'b0;
    op_ch.kind = '0;
    op_ch.item = '0;
    res_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Driver: predicts on accept, then loads the next op or idles.
  // valid is only touched when the current op is gone, so it never
  // dips between back-to-back transactions.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      op_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (op_ch.valid && op_ch.ready) predict_op(op_ch.kind, op_ch.item);
      if (!op_ch.valid || op_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          op_ch.valid <= 1'b0;
        end else if (op_backlog.size() == 0) begin
          op_ch.valid <= 1'b0;
        end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 18);  // start a burst of idle cycles
          op_ch.valid <= 1'b0;
        end else begin
          nxt_op = op_backlog.pop_front();
          op_ch.valid <= 1'b1;
          op_ch.kind <= nxt_op.kind;
          op_ch.item <= nxt_op.item;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: checks res transactions, drives ready with random stall
  // bursts and, on request, one long hold-off.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      snk_gap = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got_res.status = status_t'(res_ch.status);
        got_res.item_out = res_ch.item_out;
        got_res.item_valid = res_ch.item_valid;
        got_res.wake_producers = res_ch.wake_producers;
        got_res.wake_consumers = res_ch.wake_consumers;
        got_res.slots_used = res_ch.slots_used;
        got_res.entries_stored = res_ch.entries_stored;
        check_result(got_res);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res_ch.ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 18);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------
  initial begin
    @(negedge rst);
    @(posedge clk);

    // directed, reset limit of 16, queue empty
    queue_op(KIND_POP, '0);            // pop on empty
    queue_op(KIND_RSV_POP, '0);        // reserved pop on empty
    queue_op(KIND_REPLACE, 32'h1111_1111);  // replace with no held slot
    queue_op(KIND_RELEASE, '0);        // release with no held slot
    queue_op(3'd5, 32'hDEAD_BEEF);     // unused kinds
    queue_op(3'd6, 32'h0F0F_0F0F);
    queue_op(3'd7, 32'hF0F0_F0F0);
    queue_op(KIND_PUSH, 32'h0000_0000);  // wakes consumers
    queue_op(KIND_PUSH, 32'hFFFF_FFFF);
    queue_op(KIND_RSV_POP, '0);        // slot stays held
    queue_op(KIND_REPLACE, 32'h5A5A_5A5A);
    queue_op(KIND_RSV_POP, '0);
    queue_op(KIND_RELEASE, '0);
    queue_op(KIND_POP, '0);
    queue_op(KIND_POP, '0);

    // small limit: full refusal, held slot counts against the limit
    set_max_size(5'd2);
    queue_op(KIND_PUSH, 32'hA5A5_A5A5);
    queue_op(KIND_PUSH, 32'h1234_5678);
    queue_op(KIND_PUSH, 32'h8765_4321);  // refused full
    queue_op(KIND_RSV_POP, '0);
    queue_op(KIND_PUSH, 32'h4444_4444);  // still full: slot held
    queue_op(KIND_REPLACE, 32'h8000_0001);

    // limit lowered under the slot count
    set_max_size(5'd1);
    queue_op(KIND_PUSH, 32'h7777_7777);  // refused
    queue_op(KIND_POP, '0);              // slots 1, still at the limit
    queue_op(KIND_POP, '0);              // drops under: wakes producers

    // zero limit refuses every push
    set_max_size(5'd0);
    queue_op(KIND_PUSH, 32'h0000_0001);
    queue_op(KIND_POP, '0);

    // random phases
    set_max_size(5'd31);  // saturates to DEPTH
    queue_random(250, 60);

    // long res stall with the sender offering back to back
    set_max_size(5'd16);
    src_idle_en = 1'b0;
    hold_req++;
    queue_random(200, 70);
    wait_drained();
    src_idle_en = 1'b1;

    set_max_size(5'd1);
    queue_random(200, 50);

    set_max_size(5'd0);
    queue_random(60, 50);

    set_max_size(5'd5);
    queue_random(250, 55);

    set_max_size(5'd3);
    queue_random(200, 50);

    set_max_size(5'd8);
    queue_random(250, 45);

    // last part runs without idling on either side
    set_max_size(5'd16);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    queue_random(450, 50);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && want_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
